@@ rtl/core/sampled_dense_dot_product_top_assert.svh @@
// Assertion macros for the sampled dense dot product block.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef SAMPLED_DENSE_DOT_PRODUCT_TOP_ASSERT_SVH
`define SAMPLED_DENSE_DOT_PRODUCT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SDDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sddp: same-cycle implication failed");

// Next-cycle implication.
`define SDDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sddp: next-cycle implication failed");

`else

`define SDDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/sddp_pkg.sv @@
package sddp_pkg;

    // Default sizes
    localparam int LEFT_ROWS_DEF    = 64;
    localparam int RIGHT_ROWS_DEF   = 64;
    localparam int MAX_FEATURES_DEF = 32;

    // Field widths
    localparam int OP_W    = 2;
    localparam int ROW_W   = 6;
    localparam int FEAT_W  = 5;
    localparam int ELEM_W  = 16;
    localparam int SCALE_W = 16;
    localparam int RES_W   = 53;
    localparam int LEN_W   = 6;

    // Datapath widths: product of two Q1.15, sum of up to 63 of them, then scaled
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int ACC_W    = PROD_W + LEN_W;
    localparam int SCALED_W = ACC_W + SCALE_W;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);
    localparam logic REG_FEATURE_LENGTH = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_LEFT  = 2'd0,
        OP_WRITE_RIGHT = 2'd1,
        OP_SAMPLE      = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DRAIN,
        S_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic data_valid;
        logic scale;
    } t_mac_ctrl;

    typedef struct packed {
        logic prod_valid;
    } t_mac_stat;

endpackage

@@ rtl/core/sddp_if.sv @@
interface sddp_in_if
    import sddp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [ROW_W-1:0]         row_index;
    logic [FEAT_W-1:0]        feature_index;
    logic signed [ELEM_W-1:0] element_value;
    logic [ROW_W-1:0]         column_index;
    logic signed [SCALE_W-1:0] mask_scale;

    modport source (
        output valid, operation, row_index, feature_index, element_value,
               column_index, mask_scale,
        input  ready
    );
    modport sink (
        input  valid, operation, row_index, feature_index, element_value,
               column_index, mask_scale,
        output ready
    );
endinterface

interface sddp_out_if
    import sddp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] sampled_value;
    logic [ROW_W-1:0]        sample_row;
    logic [ROW_W-1:0]        sample_column;

    modport source (
        output valid, sampled_value, sample_row, sample_column,
        input  ready
    );
    modport sink (
        input  valid, sampled_value, sample_row, sample_column,
        output ready
    );
endinterface

@@ rtl/core/sddp_ram.sv @@
module sddp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/sddp_cfg.sv @@
module sddp_cfg
    import sddp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LEN_W-1:0]      o_feature_length
);

    logic [LEN_W-1:0] r_feature_length;
    logic             w_sel_len;

    assign w_sel_len = (paddr[PADDR_W-1] == REG_FEATURE_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_length <= LEN_RESET;
        end else if (psel && penable && pwrite && w_sel_len) begin
            r_feature_length <= pwdata[LEN_W-1:0];
        end
    end

    assign pready           = 1'b1;
    assign prdata           = w_sel_len ? {{(APB_DATA_W-LEN_W){1'b0}}, r_feature_length} : '0;
    assign o_feature_length = r_feature_length;

endmodule

@@ rtl/core/sddp_mac.sv @@
module sddp_mac
    import sddp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctrl                 i_ctrl,
    input  logic signed [ELEM_W-1:0]  i_left,
    input  logic signed [ELEM_W-1:0]  i_right,
    input  logic signed [SCALE_W-1:0] i_scale,
    output t_mac_stat                 o_stat,
    output logic signed [RES_W-1:0]   o_result
);

    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_v;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [RES_W-1:0]    r_res;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SCALED_W-1:0] w_scaled;

    assign w_prod   = i_left * i_right;
    assign w_scaled = r_acc * i_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctrl.data_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.data_valid) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        // magnitude stays below 2^51, so the top bit of the wide product is redundant
        if (i_ctrl.scale) begin
            r_res <= w_scaled[RES_W-1:0];
        end
    end

    assign o_stat.prod_valid = r_prod_v;
    assign o_result          = r_res;

endmodule

@@ rtl/core/sampled_dense_dot_product_top.sv @@
// Sampled dense-dense dot product (SDDMM) engine. Two Q1.15 feature matrices,
// left (LEFT_ROWS x MAX_FEATURES) and right (RIGHT_ROWS x MAX_FEATURES), sit in
// single-port-read synchronous RAMs. A write transaction (operation 0 or 1)
// stores one element and yields no result; writes outside the matrix are
// dropped. A sample transaction (operation 2) streams the chosen left and
// right rows through one multiply-accumulate, one element pair per cycle,
// then multiplies by the mask scale; the result has 45 fractional bits.
// Rows out of range give a zero result; feature_length is clamped to
// MAX_FEATURES. How long a sample occupies the block grows with L, the
// clamped feature length, set by the one read port per store and the single
// MAC; a write does not hold the block. The result register lets the next
// transaction start while a result waits.
// Entries must be written before a sample reads them. Program feature_length
// (byte address 0) only while the block is idle.
`include "sampled_dense_dot_product_top_assert.svh"

module sampled_dense_dot_product_top
    import sddp_pkg::*;
#(
    parameter int LEFT_ROWS    = LEFT_ROWS_DEF,
    parameter int RIGHT_ROWS   = RIGHT_ROWS_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sddp_in_if.sink               i_item,
    sddp_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEFT_DEPTH  = LEFT_ROWS * MAX_FEATURES;
    localparam int RIGHT_DEPTH = RIGHT_ROWS * MAX_FEATURES;
    localparam int LA_W = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
    localparam int RA_W = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;

    // Control state
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_k;
    logic [LEN_W-1:0] r_len;
    logic             r_rd_v;
    logic             r_out_valid;

    // Sample context and result register
    logic [LA_W-1:0]           r_a_addr;
    logic [RA_W-1:0]           r_b_addr;
    logic [ROW_W-1:0]          r_row;
    logic [ROW_W-1:0]          r_col;
    logic signed [SCALE_W-1:0] r_scale;
    logic signed [RES_W-1:0]   r_out_value;
    logic [ROW_W-1:0]          r_out_row;
    logic [ROW_W-1:0]          r_out_col;

    logic             w_accept;
    logic             w_rd_en;
    logic             w_load_out;
    logic             w_ready;
    logic             w_feat_ok;
    logic             w_wr_left;
    logic             w_wr_right;
    logic             w_in_range;
    logic [LEN_W-1:0] w_len_eff;
    logic [LEN_W-1:0] w_cfg_len;
    logic [31:0]      w_a_base;
    logic [31:0]      w_b_base;
    logic [31:0]      w_wr_row_base;
    logic [31:0]      w_wr_addr;
    logic [ELEM_W-1:0] w_left_q;
    logic [ELEM_W-1:0] w_right_q;
    logic signed [RES_W-1:0] w_mac_result;
    t_mac_ctrl        w_ctrl;
    t_mac_stat        w_stat;

    // Configuration register
    sddp_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_feature_length (w_cfg_len)
    );

    // Address arithmetic: row times a constant stride, plus the feature
    assign w_accept      = i_item.valid && w_ready;
    assign w_a_base      = 32'(i_item.row_index) * 32'(MAX_FEATURES);
    assign w_b_base      = 32'(i_item.column_index) * 32'(MAX_FEATURES);
    assign w_wr_row_base = w_a_base;
    assign w_wr_addr     = w_wr_row_base + 32'(i_item.feature_index);
    assign w_feat_ok     = 32'(i_item.feature_index) < 32'(MAX_FEATURES);

    assign w_wr_left  = w_accept && (i_item.operation == OP_WRITE_LEFT) && w_feat_ok
                        && (32'(i_item.row_index) < 32'(LEFT_ROWS));
    assign w_wr_right = w_accept && (i_item.operation == OP_WRITE_RIGHT) && w_feat_ok
                        && (32'(i_item.row_index) < 32'(RIGHT_ROWS));

    assign w_in_range = (32'(i_item.row_index) < 32'(LEFT_ROWS))
                        && (32'(i_item.column_index) < 32'(RIGHT_ROWS));
    // Clamp the programmed length to the stored row length
    assign w_len_eff  = (32'(w_cfg_len) > 32'(MAX_FEATURES)) ? LEN_W'(MAX_FEATURES)
                                                              : w_cfg_len;

    // Feature stores: written on a load, read by the sequencer during a sample
    sddp_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (LEFT_DEPTH)
    ) u_left_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_left),
        .i_wr_addr (w_wr_addr[LA_W-1:0]),
        .i_wr_data (i_item.element_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_a_addr),
        .o_rd_data (w_left_q)
    );

    sddp_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (RIGHT_DEPTH)
    ) u_right_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_right),
        .i_wr_addr (w_wr_addr[RA_W-1:0]),
        .i_wr_data (i_item.element_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_b_addr),
        .o_rd_data (w_right_q)
    );

    // Multiply-accumulate and final scaling
    sddp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_left   (w_left_q),
        .i_right  (w_right_q),
        .i_scale  (r_scale),
        .o_stat   (w_stat),
        .o_result (w_mac_result)
    );

    // Sequencer: issue reads, drain the MAC pipe, scale, hand over the result
    always_comb begin
        n_state           = r_state;
        w_ready           = 1'b0;
        w_rd_en           = 1'b0;
        w_load_out        = 1'b0;
        w_ctrl.clear      = 1'b0;
        w_ctrl.scale      = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
                if (i_item.valid && (i_item.operation == OP_SAMPLE)) begin
                    w_ctrl.clear = 1'b1;
                    n_state      = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_k == r_len) begin
                    n_state = S_DRAIN;
                end else begin
                    w_rd_en = 1'b1;
                end
            end
            S_DRAIN: begin
                // wait until the last product has reached the accumulator
                if (!r_rd_v && !w_stat.prod_valid) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                w_ctrl.scale = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free or being emptied
                if (!r_out_valid || o_result.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_ctrl.data_valid = r_rd_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_len       <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_rd_en;
            if (w_ctrl.clear) begin
                r_k   <= '0;
                // an out-of-range row reads nothing and leaves a zero sum
                r_len <= w_in_range ? w_len_eff : '0;
            end else if (w_rd_en) begin
                r_k <= r_k + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.clear) begin
            r_a_addr <= w_a_base[LA_W-1:0];
            r_b_addr <= w_b_base[RA_W-1:0];
            r_row    <= i_item.row_index;
            r_col    <= i_item.column_index;
            r_scale  <= i_item.mask_scale;
        end else if (w_rd_en) begin
            r_a_addr <= r_a_addr + 1'b1;
            r_b_addr <= r_b_addr + 1'b1;
        end
        if (w_load_out) begin
            r_out_value <= w_mac_result;
            r_out_row   <= r_row;
            r_out_col   <= r_col;
        end
    end

    assign i_item.ready           = w_ready;
    assign o_result.valid         = r_out_valid;
    assign o_result.sampled_value = r_out_value;
    assign o_result.sample_row    = r_out_row;
    assign o_result.sample_column = r_out_col;

    // Read counter never runs past the latched length
    `SDDP_ASSERT_IMP(a_fetch_count_bound, i_clk, i_rst_n, r_state == S_FETCH, r_k <= r_len)
    // Scaling only once every product has been accumulated
    `SDDP_ASSERT_IMP(a_scale_after_drain, i_clk, i_rst_n, w_ctrl.scale, !r_rd_v && !w_stat.prod_valid)
    // An accepted sample starts fetching from its first feature
    `SDDP_ASSERT_NXT(a_sample_starts_fetch, i_clk, i_rst_n, w_accept && i_item.operation == OP_SAMPLE, r_state == S_FETCH && r_k == '0)

endmodule
